// File: rtl/shortest_route_finder_defines.svh
// Assertion macros for the shortest route finder.
`ifndef SHORTEST_ROUTE_FINDER_DEFINES_SVH
`define SHORTEST_ROUTE_FINDER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define SRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/srf_pkg.sv
// Types and constants shared by the shortest route finder.
package srf_pkg;

  localparam int unsigned CITY_W  = 5;
  localparam int unsigned ROUTE_W = 10;
  localparam int unsigned MILES_W = 16;
  localparam int unsigned TOTAL_W = 21;
  localparam int unsigned DIST_W  = 30;
  localparam int unsigned MAX_HOPS = 31;
  localparam int unsigned HOP_W   = 5;

  localparam logic [DIST_W-1:0] UNREACHED = 30'h3fffffff;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] ST_HOP         = 3'd0;
  localparam logic [2:0] ST_STORED      = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_SAME        = 3'd3;
  localparam logic [2:0] ST_UNREACHABLE = 3'd4;

  typedef struct packed {
    logic               operation;
    logic [CITY_W-1:0]  node_a;
    logic [CITY_W-1:0]  node_b;
    logic [ROUTE_W-1:0] route_id;
    logic [MILES_W-1:0] miles;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [CITY_W-1:0]  from_city;
    logic [CITY_W-1:0]  to_city;
    logic [ROUTE_W-1:0] hop_route;
    logic [MILES_W-1:0] hop_miles;
    logic [TOTAL_W-1:0] total_miles;
    logic               last;
  } out_item_t;

endpackage

// File: rtl/shortest_route_finder.sv
// Shortest route finder: edge store, FIFO-queue relaxation and hop emitter.
// Edge add: accepted in IDLE, list appends in ADD1 and ADD2, then one status transfer.
// Query: POP dequeues a city, RD and REL read and relax each of its directed edges,
// then WALK follows parent links and EMIT sends the hops; input is held off meanwhile.
// Status-only answers (same city, bad index, full store) are registered straight from IDLE.
// rst (synchronous) empties all city lists, the edge count, the queue and the output.
module shortest_route_finder
  import srf_pkg::*;
#(
  parameter int unsigned MAX_CITIES         = 32,
  parameter int unsigned MAX_DIRECTED_EDGES = 512
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

`include "shortest_route_finder_defines.svh"

  localparam int unsigned CW   = $clog2(MAX_CITIES);
  localparam int unsigned UW   = $clog2(MAX_CITIES + 1);
  localparam int unsigned EW   = $clog2(MAX_DIRECTED_EDGES);
  localparam int unsigned CNTW = $clog2(MAX_DIRECTED_EDGES + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_ADD1 = 9'b000000010,
    S_ADD2 = 9'b000000100,
    S_POP  = 9'b000001000,
    S_RD   = 9'b000010000,
    S_REL  = 9'b000100000,
    S_DONE = 9'b001000000,
    S_WALK = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [CW-1:0]      to;
    logic [ROUTE_W-1:0] route;
    logic [MILES_W-1:0] miles;
  } edge_t;

  typedef struct packed {
    logic [CW-1:0]      from;
    logic [ROUTE_W-1:0] route;
    logic [MILES_W-1:0] miles;
  } link_t;

  state_t state;

  edge_t           store_mem [MAX_DIRECTED_EDGES];
  logic [EW-1:0]   next_mem  [MAX_DIRECTED_EDGES];
  edge_t           store_rd;
  logic [EW-1:0]   next_rd;

  logic [EW-1:0]         head [MAX_CITIES];
  logic [EW-1:0]         tail [MAX_CITIES];
  logic [MAX_CITIES-1:0] head_valid;
  logic [CNTW-1:0]       edge_count;

  logic [DIST_W-1:0]     best [MAX_CITIES];
  logic [MAX_CITIES-1:0] dist_valid;
  link_t                 parent [MAX_CITIES];
  logic [CW-1:0]         queue [MAX_CITIES];
  logic [MAX_CITIES-1:0] queued;
  logic [CW-1:0]         rd;
  logic [CW-1:0]         wr;
  logic [UW-1:0]         used;

  in_item_t          item;
  logic [CW-1:0]     src;
  logic [CW-1:0]     dst;
  logic [CW-1:0]     cur;
  logic [DIST_W-1:0] dist_cur;
  logic [EW-1:0]     e;

  logic [CW-1:0]      path [MAX_HOPS];
  logic [HOP_W-1:0]   n;
  logic [HOP_W-1:0]   j;
  logic [TOTAL_W-1:0] total;

  logic              out_free;
  logic              store_we;
  logic [CNTW-1:0]   store_waddr;
  edge_t             store_wdata;
  logic              next_we;
  logic [EW-1:0]     next_waddr;
  logic [CW-1:0]     app_x;
  logic [CW-1:0]     app_y;
  logic [CW-1:0]     in_a;
  logic [CW-1:0]     in_b;
  logic              bad_city;
  logic              full;
  logic [CW-1:0]     d;
  logic [DIST_W-1:0] d_best;
  logic [DIST_W:0]   nd;
  logic              improved;
  logic [CW-1:0]     wr_inc;
  logic [CW-1:0]     rd_inc;
  link_t             lk;

  function automatic out_item_t status_item(logic [2:0] st);
    out_item_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_a     = CW'(in_data.node_a);
  assign in_b     = CW'(in_data.node_b);
  assign bad_city = (int'(in_data.node_a) >= MAX_CITIES) ||
                    (int'(in_data.node_b) >= MAX_CITIES);
  assign full     = (int'(edge_count) + 2) > MAX_DIRECTED_EDGES;

  assign app_x = (state == S_ADD1) ? CW'(item.node_a) : CW'(item.node_b);
  assign app_y = (state == S_ADD1) ? CW'(item.node_b) : CW'(item.node_a);

  assign store_we    = (state == S_ADD1) || ((state == S_ADD2) && out_free);
  assign store_waddr = edge_count;
  assign store_wdata = '{to: app_y, route: item.route_id, miles: item.miles};
  assign next_we     = store_we && head_valid[app_x];
  assign next_waddr  = tail[app_x];

  assign d        = store_rd.to;
  assign d_best   = dist_valid[d] ? best[d] : UNREACHED;
  assign nd       = {1'b0, dist_cur} + (DIST_W + 1)'(store_rd.miles);
  assign improved = nd < {1'b0, d_best};
  assign wr_inc   = (wr == CW'(MAX_CITIES - 1)) ? '0 : wr + 1'b1;
  assign rd_inc   = (rd == CW'(MAX_CITIES - 1)) ? '0 : rd + 1'b1;
  assign lk       = (state == S_EMIT) ? parent[path[j]] : parent[cur];

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr[EW-1:0]] <= store_wdata;
    end
    store_rd <= store_mem[e];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= edge_count[EW-1:0];
    end
    next_rd <= next_mem[e];
  end

  always_ff @(posedge clk) begin
    logic out_valid_next;
    out_valid_next = out_valid && !out_ready;
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      head_valid <= '0;
      edge_count <= '0;
      dist_valid <= '0;
      queued     <= '0;
      used       <= '0;
      rd         <= '0;
      wr         <= '0;
    end else begin
      if (store_we) begin
        if (!head_valid[app_x]) begin
          head[app_x]       <= edge_count[EW-1:0];
          head_valid[app_x] <= 1'b1;
        end
        tail[app_x] <= edge_count[EW-1:0];
        edge_count  <= edge_count + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item     <= in_data;
            src      <= in_a;
            dst      <= in_b;
            if (in_data.operation == OP_ADD) begin
              if (bad_city || full) begin
                out_data       <= status_item(ST_FULL);
                out_valid_next = 1'b1;
              end else begin
                state <= S_ADD1;
              end
            end else if (in_data.node_a == in_data.node_b) begin
              out_data       <= status_item(ST_SAME);
              out_valid_next = 1'b1;
            end else if (bad_city) begin
              out_data       <= status_item(ST_UNREACHABLE);
              out_valid_next = 1'b1;
            end else begin
              best[in_a] <= '0;
              dist_valid <= MAX_CITIES'(1) << in_a;
              queued     <= MAX_CITIES'(1) << in_a;
              queue[0]   <= in_a;
              rd         <= '0;
              wr         <= (MAX_CITIES > 1) ? CW'(1) : '0;
              used       <= UW'(1);
              state      <= S_POP;
            end
          end
        end
        S_ADD1: begin
          state <= S_ADD2;
        end
        S_ADD2: begin
          if (out_free) begin
            out_data       <= status_item(ST_STORED);
            out_valid_next = 1'b1;
            state          <= S_IDLE;
          end
        end
        S_POP: begin
          if (used == '0) begin
            state <= S_DONE;
          end else begin
            cur                <= queue[rd];
            dist_cur           <= best[queue[rd]];
            queued[queue[rd]]  <= 1'b0;
            rd                 <= rd_inc;
            used               <= used - 1'b1;
            e                  <= head[queue[rd]];
            if (head_valid[queue[rd]]) begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_REL;
        end
        S_REL: begin
          if (improved) begin
            best[d]       <= nd[DIST_W-1:0];
            dist_valid[d] <= 1'b1;
            parent[d]     <= '{from: cur, route: store_rd.route, miles: store_rd.miles};
            if (!queued[d] && (int'(used) < MAX_CITIES)) begin
              queued[d] <= 1'b1;
              queue[wr] <= d;
              wr        <= wr_inc;
              used      <= used + 1'b1;
            end
          end
          if (e == tail[cur]) begin
            state <= S_POP;
          end else begin
            e     <= next_rd;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (!dist_valid[dst]) begin
            if (out_free) begin
              out_data       <= status_item(ST_UNREACHABLE);
              out_valid_next = 1'b1;
              state          <= S_IDLE;
            end
          end else begin
            cur   <= dst;
            n     <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if ((cur != src) && (int'(n) < MAX_HOPS)) begin
            path[n] <= cur;
            n       <= n + 1'b1;
            cur     <= lk.from;
          end else begin
            j     <= n - 1'b1;
            total <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            total     <= total + TOTAL_W'(lk.miles);
            out_data  <= '{status: ST_HOP, from_city: CITY_W'(lk.from),
                           to_city: CITY_W'(path[j]), hop_route: lk.route,
                           hop_miles: lk.miles,
                           total_miles: total + TOTAL_W'(lk.miles),
                           last: (j == '0)};
            out_valid_next = 1'b1;
            if (j == '0) begin
              state <= S_IDLE;
            end else begin
              j <= j - 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      out_valid <= out_valid_next;
    end
  end

  `SRF_ASSERT_NOW(a_queue_flags, clk, rst, 1'b1, $countones(queued) == int'(used), "queue flags disagree with queue fill")
  `SRF_ASSERT_NEXT(a_count_mono, clk, rst, 1'b1, edge_count >= $past(edge_count), "edge count went down")
  `SRF_ASSERT_NEXT(a_add_start, clk, rst, in_valid && in_ready && (in_data.operation == OP_ADD) && !bad_city && !full, state == S_ADD1, "edge transfer did not start append")

endmodule

// File: dv/testbench.sv
// Testbench for shortest_route_finder: random road graphs and route queries vs a predictor.
`timescale 1ns / 1ps
module testbench;
  import srf_pkg::*;

  localparam int unsigned CITIES = 32;
  localparam int unsigned SLOTS = 512;
  localparam logic [9:0] NO_LINK = 10'd512;
  localparam int unsigned IDLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  in_item_t in_data = '0;
  logic in_ready;
  logic out_valid;
  out_item_t out_data;

  shortest_route_finder uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // road graph copy
  logic [4:0]  road_to [SLOTS];
  logic [9:0]  road_route [SLOTS];
  logic [15:0] road_miles [SLOTS];
  logic [9:0]  road_next [SLOTS];
  logic [9:0]  head_of [CITIES];
  logic [9:0]  tail_of [CITIES];
  int unsigned road_count;

  in_item_t  pending_items[$];
  out_item_t expected_hops[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit stimulus_done = 1'b0;

  function automatic out_item_t status_only(logic [2:0] st);
    out_item_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void add_expected(out_item_t r);
    expected_hops = {expected_hops, r};
  endfunction

  function automatic void add_pending(in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void link_road(int a, int b, logic [9:0] rt, logic [15:0] mi);
    int e;
    e = road_count;
    road_to[e] = b[4:0];
    road_route[e] = rt;
    road_miles[e] = mi;
    road_next[e] = NO_LINK;
    if (head_of[a] == NO_LINK) head_of[a] = e[9:0];
    else road_next[tail_of[a]] = e[9:0];
    tail_of[a] = e[9:0];
    road_count = e + 1;
  endfunction

  function automatic void predict_route(in_item_t it);
    logic [31:0] best_len [CITIES];
    int unsigned par_from [CITIES];
    logic [9:0] par_route [CITIES];
    logic [15:0] par_miles [CITIES];
    bit queued [CITIES];
    int unsigned fifo [$];
    int unsigned path [$];
    int unsigned o, d, c, src, dst;
    logic [31:0] nd;
    logic [20:0] total;
    logic [9:0] e;
    out_item_t r;
    src = it.node_a;
    dst = it.node_b;
    if (it.operation == OP_ADD) begin
      if (road_count + 2 > SLOTS) begin
        add_expected(status_only(ST_FULL));
      end else begin
        link_road(src, dst, it.route_id, it.miles);
        link_road(dst, src, it.route_id, it.miles);
        add_expected(status_only(ST_STORED));
      end
      return;
    end
    if (src == dst) begin
      add_expected(status_only(ST_SAME));
      return;
    end
    for (int i = 0; i < CITIES; i++) begin
      best_len[i] = UNREACHED;
      queued[i] = 1'b0;
      par_from[i] = i;
      par_route[i] = '0;
      par_miles[i] = '0;
    end
    best_len[src] = 0;
    fifo = {fifo, src};
    queued[src] = 1'b1;
    while (fifo.size() > 0) begin
      o = fifo.pop_front();
      queued[o] = 1'b0;
      e = head_of[o];
      while (e != NO_LINK) begin
        d = road_to[e];
        nd = best_len[o] + road_miles[e];
        if (nd < best_len[d]) begin
          best_len[d] = nd;
          par_from[d] = o;
          par_route[d] = road_route[e];
          par_miles[d] = road_miles[e];
          if (!queued[d] && fifo.size() < CITIES) begin
            queued[d] = 1'b1;
            fifo = {fifo, d};
          end
        end
        e = road_next[e];
      end
    end
    if (best_len[dst] == UNREACHED) begin
      add_expected(status_only(ST_UNREACHABLE));
      return;
    end
    c = dst;
    while (c != src && path.size() < MAX_HOPS) begin
      path.push_front(c);
      c = par_from[c];
    end
    total = '0;
    foreach (path[j]) begin
      total += par_miles[path[j]];
      r.status = ST_HOP;
      r.from_city = 5'(par_from[path[j]]);
      r.to_city = 5'(path[j]);
      r.hop_route = par_route[path[j]];
      r.hop_miles = par_miles[path[j]];
      r.total_miles = total;
      r.last = (j == path.size() - 1);
      add_expected(r);
    end
  endfunction

  function automatic int draw_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  int send_gap = 0;
  int take_gap = 0;
  bit calm = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_route(in_data);
        send_gap <= calm ? 0 : draw_gap();
        if (pending_items.size() > 0 && (calm || $urandom_range(0, 1) == 0)) begin
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_hops.size() == 0) begin
          $display("%0t unexpected transfer: actual %p", $time, out_data);
          fail_count++;
        end else begin
          out_item_t want;
          want = expected_hops.pop_front();
          if (want !== out_data) begin
            $display("%0t transfer differs: expected %p actual %p", $time, want, out_data);
            fail_count++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        take_gap <= draw_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("shortest_route_finder: mismatch");
        $finish;
      end
    end
  end

  function automatic in_item_t make_edge(int a, int b, int rt, int mi);
    in_item_t it;
    it.operation = OP_ADD;
    it.node_a = 5'(a);
    it.node_b = 5'(b);
    it.route_id = 10'(rt);
    it.miles = 16'(mi);
    return it;
  endfunction

  function automatic in_item_t make_query(int a, int b);
    in_item_t it;
    it = make_edge(a, b, $urandom_range(0, 1023), $urandom_range(0, 65535));
    it.operation = OP_QUERY;
    return it;
  endfunction

  initial begin
    int span;
    int made;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed: chains, extremes, self loop, same city, unreachable
    add_pending(make_query(3, 3));
    add_pending(make_query(0, 31));
    add_pending(make_edge(0, 1, 1023, 65535));
    add_pending(make_edge(1, 2, 0, 0));
    add_pending(make_edge(2, 31, 682, 21845));
    add_pending(make_edge(0, 31, 341, 43690));
    add_pending(make_edge(5, 5, 7, 9));
    add_pending(make_query(0, 31));
    add_pending(make_query(31, 0));
    add_pending(make_query(5, 0));
    add_pending(make_query(0, 5));
    for (int i = 6; i < 31; i++) add_pending(make_edge(i, i + 1, i, 1));
    add_pending(make_edge(31, 6, 1023, 65535));
    add_pending(make_query(6, 31));
    add_pending(make_query(7, 6));
    // random: edge bursts and queries; later edges overflow the store
    made = 0;
    while (made < 500) begin
      span = $urandom_range(0, 2) == 0 ? 31 : 7;
      if ($urandom_range(0, 2) != 0) begin
        add_pending(make_edge($urandom_range(0, span), $urandom_range(0, span),
                              $urandom_range(0, 1023),
                              $urandom_range(0, 3) == 0 ?
                              $urandom_range(0, 65535) : $urandom_range(0, 50)));
      end else begin
        add_pending(make_query($urandom_range(0, span), $urandom_range(0, span)));
      end
      made++;
      if (made == 250) calm = 1'b1;
      if (made == 300) calm = 1'b0;
    end
    stimulus_done = 1'b1;
  end

  initial begin
    road_count = 0;
    for (int i = 0; i < CITIES; i++) begin
      head_of[i] = NO_LINK;
      tail_of[i] = NO_LINK;
    end
    wait (stimulus_done && pending_items.size() == 0 && !in_valid);
    wait (expected_hops.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("shortest_route_finder: match");
    end else begin
      $display("shortest_route_finder: mismatch");
    end
    $finish;
  end

endmodule
